// ===== src/alpu_pkg.sv =====
// ----------------------------------------------------------------------------
// alpu_pkg
// Shared types and constants for the penalty update block.
// ----------------------------------------------------------------------------
package alpu_pkg;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_W  = 31;
  localparam int QUO_W  = 16;

  localparam logic [31:0] RHO_NOM_RST = 32'd65536;
  localparam logic [31:0] RHO_MIN_RST = 32'd6554;
  localparam logic [31:0] RHO_MAX_RST = 32'd655360;
  localparam logic [16:0] ALPHA_RST   = 17'd32768;
  localparam logic [16:0] ALPHA_ONE   = 17'h10000;
  localparam logic [30:0] V31_MAX     = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_KIND  = 3'd0;
  localparam logic [2:0] REG_RMIN  = 3'd1;
  localparam logic [2:0] REG_RMAX  = 3'd2;
  localparam logic [2:0] REG_RNOM  = 3'd3;
  localparam logic [2:0] REG_ALPHA = 3'd4;
  localparam logic [2:0] REG_DEACT = 3'd5;
  localparam logic [2:0] REG_ASET  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_UPD, ST_ACT, ST_DIV,
    ST_MUL2, ST_TGT, ST_MUL3, ST_MUL4, ST_FIN
  } state_e;

endpackage

// ===== src/alpu_ifs.sv =====
// ----------------------------------------------------------------------------
// alpu interfaces
// Input, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alpu_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        component;
  logic signed [31:0] constraint_value;
  logic              factor_valid;
  logic              last_component;
  modport source(output valid, component, constraint_value, factor_valid,
                 last_component, input ready);
  modport sink(input valid, component, constraint_value, factor_valid,
               last_component, output ready);
endinterface

interface alpu_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        component_out;
  logic signed [31:0] multiplier_out;
  logic [31:0]       rho_out;
  logic [30:0]       violation_out;
  logic              active_out;
  logic [30:0]       max_violation_out;
  logic              updated_out;
  logic              last_out;
  modport source(output valid, component_out, multiplier_out, rho_out,
                 violation_out, active_out, max_violation_out, updated_out,
                 last_out, input ready);
  modport sink(input valid, component_out, multiplier_out, rho_out,
               violation_out, active_out, max_violation_out, updated_out,
               last_out, output ready);
endinterface

interface alpu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/alpu_ram.sv =====
// ----------------------------------------------------------------------------
// alpu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module alpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/alpu_serial_mul.sv =====
// ----------------------------------------------------------------------------
// alpu_serial_mul
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module alpu_serial_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [alpu_pkg::MUL_AW-1:0]    a_i,
  input  logic [alpu_pkg::MUL_BW-1:0]    b_i,
  output logic                           done_o,
  output logic [alpu_pkg::MUL_PW-1:0]    prod_o
);
  import alpu_pkg::*;

  localparam int CW = $clog2(MUL_BW + 1);

  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW:0]   hi_q;
  logic [MUL_BW-1:0] lo_q;
  logic [MUL_AW:0]   sum;

  assign sum = hi_q + (lo_q[0] ? {a_q[MUL_AW-1], a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i && cnt_q == '0 && !done_q) begin
        cnt_q <= CW'(MUL_BW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && cnt_q == '0 && !done_q) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= {sum[MUL_AW], sum[MUL_AW:1]};
      lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[MUL_AW-1:0], lo_q};
endmodule

// ===== src/alpu_serial_div.sv =====
// ----------------------------------------------------------------------------
// alpu_serial_div
// Restoring divider for a fraction num/den < 1, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alpu_serial_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alpu_pkg::DIV_W-1:0]  num_i,
  input  logic [alpu_pkg::DIV_W-1:0]  den_i,
  output logic                        done_o,
  output logic [alpu_pkg::QUO_W-1:0]  quo_o
);
  import alpu_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W:0]   rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DIV_W:0]   rem2;
  logic             ge;

  assign rem2 = {rem_q[DIV_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i && cnt_q == '0 && !done_q) begin
        cnt_q <= CW'(QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && cnt_q == '0 && !done_q) begin
      den_q <= den_i;
      rem_q <= {1'b0, num_i};
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? (rem2 - {1'b0, den_q}) : rem2;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== src/augmented_lagrangian_penalty_update.sv =====
// ----------------------------------------------------------------------------
// augmented_lagrangian_penalty_update
// Per-component Lagrange multiplier and penalty update.
// ----------------------------------------------------------------------------
// Usage: items enter on in_i (component, constraint value, factor valid,
// last flag); one result word per item leaves on out_o. cfg_i writes the
// seven registers by index; write only while the block is idle.
// Items are handled one at a time. From acceptance to the result register a
// word goes through a read, one serial multiply pass and bookkeeping when no
// penalty update is due; when the penalty is updated, it takes four passes
// of the bit-serial multiplier and, when the violation changed, a pass of
// the serial divider. The block returns to idle after each word before the
// next is accepted. The multiplier is the rate-setting unit.
// Per-component state lives in a RAM; an entry never written reads as its
// reset value through a valid bit, so no clearing pass is needed.
// Reset clears control state and valid bits and loads register defaults.
// The result sits in an output register; a stalled receiver holds it there,
// and the next item is accepted but waits for that register before finishing.
// ----------------------------------------------------------------------------
module augmented_lagrangian_penalty_update #(
  parameter int CONSTRAINT_DIM = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  alpu_in_if.sink        in_i,
  alpu_out_if.source     out_o,
  alpu_cfg_if.sink       cfg_i
);
  import alpu_pkg::*;

  localparam int AW = (CONSTRAINT_DIM > 1) ? $clog2(CONSTRAINT_DIM) : 1;
  localparam int RW = 32 + 32 + 31;

  state_e state_q, state_d;

  logic        kind_q, deact_q, aset_q;
  logic [31:0] rmin_q, rmax_q, rnom_q;
  logic [16:0] alpha_q;

  logic [AW-1:0]             addr_q;
  logic [2:0]                comp_q;
  logic signed [31:0]        c_q;
  logic                      valid_q, last_q, inr_q;
  logic signed [31:0]        m_q;
  logic [31:0]               rho_q;
  logic [30:0]               prev_q, v_q, dnum_q, dden_q;
  logic                      act_q, dsel_q;
  logic [QUO_W:0]            x_q;
  logic [31:0]               tgt_q;
  logic [49:0]               acc_q;
  logic                      started_q;
  logic [30:0]               rmax_run_q;
  logic [CONSTRAINT_DIM-1:0] ent_vld_q, active_q;

  logic              ov_q;
  logic [2:0]        o_comp_q;
  logic [31:0]       o_m_q, o_rho_q;
  logic [30:0]       o_v_q, o_max_q;
  logic              o_act_q, o_upd_q, o_last_q;

  logic              in_acc, upd, need_div, fin_go, ram_we;
  logic              mul_start, mul_done, div_start, div_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [AW-1:0]     ram_addr;
  logic [RW-1:0]     ram_rdata, ram_wdata;
  logic [16:0]       a_eff;
  logic signed [MUL_PW-1:0] p_s, t_s, msum, act_sum, num;
  logic signed [31:0] m_new;
  logic [30:0]       v_c, prev_fin, maxv;
  logic              inr_c;

  assign in_acc = in_i.valid && in_i.ready;
  assign upd    = inr_q && valid_q && started_q;
  assign a_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign p_s    = signed'(prod);
  assign inr_c  = 32'(in_i.component) < CONSTRAINT_DIM;

  // config
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= 1'b0;
      rmin_q  <= RHO_MIN_RST;
      rmax_q  <= RHO_MAX_RST;
      rnom_q  <= RHO_NOM_RST;
      alpha_q <= ALPHA_RST;
      deact_q <= 1'b0;
      aset_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KIND:  kind_q  <= cfg_i.data[0];
        REG_RMIN:  rmin_q  <= cfg_i.data;
        REG_RMAX:  rmax_q  <= cfg_i.data;
        REG_RNOM:  rnom_q  <= cfg_i.data;
        REG_ALPHA: alpha_q <= cfg_i.data[16:0];
        REG_DEACT: deact_q <= cfg_i.data[0];
        REG_ASET:  aset_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // violation of the held value
  always_comb begin
    if (kind_q) begin
      v_c = (c_q > 0) ? c_q[30:0] : '0;
    end else if (c_q < 0) begin
      v_c = (c_q == 32'sh8000_0000) ? V31_MAX : 31'(-c_q);
    end else begin
      v_c = c_q[30:0];
    end
  end

  // multiplier update: m + floor(rho*c / 2^16), saturate, clamp
  always_comb begin
    t_s  = p_s >>> 16;
    msum = MUL_PW'(m_q) + t_s;
    if (msum > MUL_PW'(32'sh7FFF_FFFF)) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (msum < MUL_PW'(32'sh8000_0000)) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = msum[31:0];
    end
    if (kind_q && m_new < 0) begin
      m_new = '0;
    end
  end

  assign act_sum  = p_s + (MUL_PW'(m_q) <<< 16);
  assign need_div = (prev_q != '0 && v_q < prev_q) || (v_q != '0 && v_q > prev_q);
  assign num      = (MUL_PW'(signed'({1'b0, rnom_q})) <<< 16) + p_s;

  // serial units; the multiplier is shared by the four multiply states
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL1: begin
        mul_a = MUL_AW'(c_q);
        mul_b = rho_q;
      end
      ST_MUL2: begin
        mul_a = dsel_q ? ({2'b0, rmax_q} - {2'b0, rnom_q})
                       : ({2'b0, rmin_q} - {2'b0, rnom_q});
        mul_b = MUL_BW'(x_q);
      end
      ST_MUL3: begin
        mul_a = {2'b0, tgt_q};
        mul_b = MUL_BW'(a_eff);
      end
      ST_MUL4: begin
        mul_a = {2'b0, rho_q};
        mul_b = MUL_BW'(ALPHA_ONE - a_eff);
      end
      default: ;
    endcase
  end

  alpu_serial_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(prod)
  );

  alpu_serial_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(dnum_q), .den_i(dden_q),
    .done_o(div_done), .quo_o(quo)
  );

  // per-component store
  assign ram_addr  = (state_q == ST_IDLE) ? AW'(in_i.component) : addr_q;
  assign prev_fin  = valid_q ? v_q : prev_q;
  assign ram_wdata = {m_q, rho_q, prev_fin};

  alpu_ram #(.WIDTH(RW), .DEPTH(CONSTRAINT_DIM)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: state_d = ST_MUL1;
      ST_MUL1: if (mul_done) state_d = ST_UPD;
      ST_UPD:  state_d = ST_ACT;
      ST_ACT: begin
        if (!upd) state_d = ST_FIN;
        else if (need_div) state_d = ST_DIV;
        else state_d = ST_MUL2;
      end
      ST_DIV:  if (div_done) state_d = ST_MUL2;
      ST_MUL2: if (mul_done) state_d = ST_TGT;
      ST_TGT:  state_d = ST_MUL3;
      ST_MUL3: if (mul_done) state_d = ST_MUL4;
      ST_MUL4: if (mul_done) state_d = ST_FIN;
      ST_FIN:  if (!ov_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    fin_go     = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: mul_start = 1'b1;
      ST_DIV:  div_start = 1'b1;
      ST_FIN:  fin_go = !ov_q || out_o.ready;
      default: ;
    endcase
  end

  assign ram_we = fin_go && inr_q;
  assign maxv   = (inr_q && valid_q && v_q > rmax_run_q) ? v_q : rmax_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      started_q  <= 1'b0;
      rmax_run_q <= '0;
      ent_vld_q  <= '0;
      active_q   <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        ov_q       <= 1'b1;
        rmax_run_q <= last_q ? '0 : maxv;
        if (last_q && valid_q) begin
          started_q <= 1'b1;
        end
        if (inr_q) begin
          ent_vld_q[addr_q] <= 1'b1;
          active_q[addr_q]  <= act_q;
        end
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          addr_q  <= AW'(in_i.component);
          comp_q  <= in_i.component;
          c_q     <= in_i.constraint_value;
          valid_q <= in_i.factor_valid;
          last_q  <= in_i.last_component;
          inr_q   <= inr_c;
        end
      end
      ST_READ: begin
        if (inr_q && ent_vld_q[addr_q]) begin
          m_q    <= ram_rdata[RW-1:63];
          rho_q  <= ram_rdata[62:31];
          prev_q <= ram_rdata[30:0];
        end else begin
          m_q    <= '0;
          rho_q  <= RHO_NOM_RST;
          prev_q <= '0;
        end
        act_q <= inr_q ? active_q[addr_q] : 1'b0;
      end
      ST_UPD: begin
        if (started_q) begin
          m_q <= m_new;
        end
        v_q <= v_c;
      end
      ST_ACT: begin
        if (valid_q && kind_q) begin
          if (act_sum > 0) begin
            act_q <= 1'b1;
          end else if (deact_q && aset_q) begin
            act_q <= 1'b0;
          end
        end
        if (prev_q != '0 && v_q < prev_q) begin
          dsel_q <= 1'b1;
          dnum_q <= prev_q - v_q;
          dden_q <= prev_q;
        end else begin
          dsel_q <= 1'b0;
          dnum_q <= v_q - prev_q;
          dden_q <= v_q;
        end
        x_q <= '0;
      end
      // equal operands give a full-scale ratio of one
      ST_DIV:  if (div_done) x_q <= (dnum_q == dden_q) ? {1'b1, QUO_W'(0)} : {1'b0, quo};
      ST_TGT:  tgt_q <= (num < 0) ? '0 : num[47:16];
      ST_MUL3: if (mul_done) acc_q <= prod[49:0];
      ST_MUL4: if (mul_done) rho_q <= 32'((acc_q + prod[49:0]) >> 16);
      ST_FIN: begin
        if (fin_go) begin
          o_comp_q <= comp_q;
          o_m_q    <= inr_q ? m_q : '0;
          o_rho_q  <= inr_q ? rho_q : '0;
          o_v_q    <= (inr_q && valid_q) ? v_q : '0;
          o_act_q  <= inr_q && act_q;
          o_max_q  <= maxv;
          o_upd_q  <= upd;
          o_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid             = ov_q;
  assign out_o.component_out     = o_comp_q;
  assign out_o.multiplier_out    = o_m_q;
  assign out_o.rho_out           = o_rho_q;
  assign out_o.violation_out     = o_v_q;
  assign out_o.active_out        = o_act_q;
  assign out_o.max_violation_out = o_max_q;
  assign out_o.updated_out       = o_upd_q;
  assign out_o.last_out          = o_last_q;
endmodule
